// ===== rtl/digraph_reachability_engine_macros.svh =====
// Assertion helpers used by the engine top level to check its request queue.
`ifndef DIGRAPH_REACHABILITY_ENGINE_MACROS_SVH
`define DIGRAPH_REACHABILITY_ENGINE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DRE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dre_pkg.sv =====
`default_nettype none
package dre_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VTX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int ARC_W        = 12;
    localparam int FUNC_W       = 2;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_INSERT,
        KIND_REMOVE,
        KIND_QUERY,
        KIND_BAD
    } dre_kind_t;

    typedef struct packed {
        dre_kind_t         kind;
        logic [VTX_W-1:0]  first;
        logic [VTX_W-1:0]  second;
        logic [CNT_W-1:0]  n;
    } dre_op_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } dre_qstat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW,
        ST_ROWA,
        ST_SWEEP,
        ST_PICK,
        ST_EXPAND,
        ST_FINISH
    } dre_state_t;

    // Bits below the active vertex count.
    function automatic logic [MAX_VERTICES-1:0] low_mask(input logic [CNT_W-1:0] n);
        logic [MAX_VERTICES-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            m[i] = (CNT_W'(i) < n);
        end
        return m;
    endfunction

    // Index of the lowest set bit; zero when the vector is empty.
    function automatic logic [VTX_W-1:0] lowest_index(input logic [MAX_VERTICES-1:0] v);
        logic [VTX_W-1:0] idx;
        idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = VTX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/dre_front.sv =====
`default_nettype none
module dre_front
    import dre_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CNT_W-1:0]     cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [FUNC_W-1:0]    s_tuser,
    input  wire dre_qstat_t           q_stat,
    output logic                      push,
    output dre_op_t                   push_op
);

    logic [CNT_W-1:0] vertex_count_reg;
    logic [CNT_W-1:0] active_n;
    logic [VTX_W-1:0] first_v;
    logic [VTX_W-1:0] second_v;
    logic             out_of_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= CNT_W'(MAX_VERTICES);
        end else if (cfg_valid) begin
            vertex_count_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_stat.full;
    assign push      = s_tvalid && !q_stat.full;

    assign first_v  = s_tdata[VTX_W-1:0];
    assign second_v = s_tdata[2*VTX_W-1:VTX_W];
    assign active_n = (vertex_count_reg > CNT_W'(MAX_VERTICES)) ?
                      CNT_W'(MAX_VERTICES) : vertex_count_reg;
    assign out_of_range = ({1'b0, first_v} >= active_n) || ({1'b0, second_v} >= active_n);

    always_comb begin
        push_op.first  = first_v;
        push_op.second = second_v;
        push_op.n      = active_n;
        case (s_tuser)
            FUNC_INSERT: push_op.kind = out_of_range ? KIND_BAD : KIND_INSERT;
            FUNC_REMOVE: push_op.kind = out_of_range ? KIND_BAD : KIND_REMOVE;
            FUNC_QUERY:  push_op.kind = out_of_range ? KIND_BAD : KIND_QUERY;
            default:     push_op.kind = KIND_NOP;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/dre_queue.sv =====
`default_nettype none
module dre_queue
    import dre_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire dre_op_t push_op,
    input  wire logic    pop,
    output dre_op_t      head,
    output dre_qstat_t   q_stat
);

    dre_op_t           entry_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.count = count_reg;
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = entry_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_mem[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                              wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                              rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dre_back.sv =====
`default_nettype none
module dre_back
    import dre_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire dre_op_t              head,
    input  wire dre_qstat_t           q_stat,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    // Adjacency rows; a row whose valid bit is clear reads as all zeros.
    logic [MAX_VERTICES-1:0] row_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic [MAX_VERTICES-1:0] rd_data_reg;
    logic                    rd_hit_reg;

    dre_state_t              state_reg;
    dre_state_t              state_next;
    dre_op_t                 op_reg;
    logic [VTX_W-1:0]        k_reg;
    logic [MAX_VERTICES-1:0] rowa_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] expanded_reg;
    logic [VTX_W-1:0]        outd_reg;
    logic [VTX_W-1:0]        ind_reg;
    logic                    reach_reg;
    logic                    chg_reg;
    logic                    bad_reg;
    logic [ARC_W-1:0]        arcs_reg;
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    logic                    rd_en;
    logic [VTX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [MAX_VERTICES-1:0] wr_data;
    logic                    load_out;
    logic [MAX_VERTICES-1:0] row_rd;
    logic [MAX_VERTICES-1:0] mask;
    logic [MAX_VERTICES-1:0] cand;
    logic [VTX_W-1:0]        pick;
    logic [MAX_VERTICES-1:0] second_bit;
    logic                    arc_bit;
    logic                    last_k;
    logic                    head_uses_row;

    assign row_rd     = rd_hit_reg ? rd_data_reg : '0;
    assign mask       = low_mask(op_reg.n);
    assign cand       = visited_reg & ~expanded_reg;
    assign pick       = lowest_index(cand);
    assign second_bit = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << op_reg.second;
    assign arc_bit    = row_rd[op_reg.second];
    assign last_k     = ({1'b0, k_reg} == (op_reg.n - CNT_W'(1)));
    assign head_uses_row = (head.kind == KIND_INSERT) || (head.kind == KIND_REMOVE) ||
                           (head.kind == KIND_QUERY);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[op_reg.first] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= row_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_hit_reg    <= 1'b0;
        end else begin
            if (wr_en) begin
                row_valid_reg[op_reg.first] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    case (head.kind)
                        KIND_INSERT, KIND_REMOVE: state_next = ST_RMW;
                        KIND_QUERY:               state_next = ST_ROWA;
                        default:                  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_RMW:    state_next = ST_FINISH;
            ST_ROWA:   state_next = ST_SWEEP;
            ST_SWEEP:  state_next = last_k ? ST_PICK : ST_SWEEP;
            ST_PICK:   state_next = (cand == '0) ? ST_FINISH : ST_EXPAND;
            ST_EXPAND: state_next = ST_PICK;
            ST_FINISH: state_next = load_out ? ST_IDLE : ST_FINISH;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pop      = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_data  = row_rd;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                pop     = !q_stat.empty;
                rd_en   = !q_stat.empty && head_uses_row;
                rd_addr = head.first;
            end
            ST_RMW: begin
                if (op_reg.kind == KIND_INSERT) begin
                    wr_en   = (op_reg.first != op_reg.second) && !arc_bit;
                    wr_data = row_rd | second_bit;
                end else begin
                    wr_en   = arc_bit;
                    wr_data = row_rd & ~second_bit;
                end
            end
            ST_ROWA: begin
                rd_en = 1'b1;
            end
            ST_SWEEP: begin
                rd_en   = !last_k;
                rd_addr = k_reg + VTX_W'(1);
            end
            ST_PICK: begin
                rd_en   = (cand != '0);
                rd_addr = pick;
            end
            ST_FINISH: begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            arcs_reg     <= '0;
            visited_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_RMW && wr_en) begin
                if (op_reg.kind == KIND_INSERT) begin
                    arcs_reg <= arcs_reg + ARC_W'(1);
                end else if (arcs_reg != '0) begin
                    arcs_reg <= arcs_reg - ARC_W'(1);
                end
            end
            if (state_reg == ST_SWEEP && last_k) begin
                visited_reg <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << op_reg.first;
            end else if (state_reg == ST_EXPAND) begin
                visited_reg <= visited_reg | (row_rd & mask);
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    op_reg    <= head;
                    outd_reg  <= '0;
                    ind_reg   <= '0;
                    reach_reg <= 1'b0;
                    chg_reg   <= 1'b0;
                    bad_reg   <= (head.kind == KIND_BAD);
                end
            end
            ST_RMW: begin
                chg_reg <= wr_en;
            end
            ST_ROWA: begin
                rowa_reg <= row_rd;
                k_reg    <= '0;
            end
            ST_SWEEP: begin
                ind_reg  <= ind_reg + VTX_W'(arc_bit);
                outd_reg <= outd_reg + VTX_W'(rowa_reg[k_reg]);
                k_reg    <= k_reg + VTX_W'(1);
                if (last_k) begin
                    expanded_reg <= '0;
                end
            end
            ST_PICK: begin
                if (cand == '0) begin
                    reach_reg <= visited_reg[op_reg.second];
                end else begin
                    expanded_reg[pick] <= 1'b1;
                end
            end
            ST_FINISH: begin
                if (load_out) begin
                    m_tdata_reg <= {5'b0, bad_reg, chg_reg, arcs_reg, ind_reg, outd_reg,
                                    reach_reg};
                end
            end
            default: begin
                k_reg <= k_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

// ===== rtl/digraph_reachability_engine.sv =====
// Channel   Direction  Handshake             Payload
// s_        in         s_tvalid / s_tready   s_tdata: first, second vertex; s_tuser: func
// m_        out        m_tvalid / m_tready   m_tdata: reach, degrees, arc count, flags
// cfg_      in         cfg_valid / cfg_ready cfg_data: vertex_count
//
// Insert and remove pass through the IDLE, RMW and FINISH states of the back end; bad-vertex
// and unused requests go from IDLE straight to FINISH. A query reads the first vertex's row,
// sweeps the n active vertices for both degrees, then picks and expands each reached vertex.
// Reset is synchronous; it clears the row valid bits directly, so no clearing pass.
// A two-entry request queue and the output register let either side stall freely.
`default_nettype none
module digraph_reachability_engine
    import dre_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CNT_W-1:0]     cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [5:0] first_vertex, [11:6] second_vertex, [15:12] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] func
    input  wire logic [FUNC_W-1:0]    s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] reachable, [6:1] out_degree, [12:7] in_degree, [24:13] arc_count,
    // [25] changed, [26] bad_vertex, [31:27] zero
    output logic [M_TDATA_W-1:0]      m_tdata
);

`include "digraph_reachability_engine_macros.svh"

    dre_qstat_t q_stat;
    dre_op_t    push_op;
    dre_op_t    head;
    logic       push;
    logic       pop;

    dre_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_stat    (q_stat),
        .push      (push),
        .push_op   (push_op)
    );

    dre_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .q_stat  (q_stat)
    );

    dre_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `DRE_ASSERT_IMP(a_push_not_full, push, !q_stat.full, "request pushed into a full queue")
    `DRE_ASSERT_IMP(a_pop_not_empty, pop, !q_stat.empty, "request popped from an empty queue")
    `DRE_ASSERT_IMP(a_count_bound, 1'b1, q_stat.count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
    `DRE_ASSERT_NEXT(a_push_lands, s_tvalid && s_tready && q_stat.empty, !q_stat.empty,
        "accepted request lost before the back end")

endmodule
`default_nettype wire

// ===== tb/sv/tb_digraph_reachability_engine.sv =====
`timescale 1ns / 100ps

module tb_digraph_reachability_engine;
    import dre_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic             reach;
        logic [VTX_W-1:0] out_deg;
        logic [VTX_W-1:0] in_deg;
        logic [ARC_W-1:0] arcs;
        logic             changed;
        logic             bad;
    } graph_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [FUNC_W-1:0]    s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the graph and the vertex count register.
    logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
    int unsigned             arc_total;
    logic [CNT_W-1:0]        vtx_reg;

    graph_result_t expected_results [$];
    bit steady_flow;
    int errors;
    int requests_sent;
    int queries_sent;
    int reach_hits;
    int bad_hits;
    int settings_used;

    digraph_reachability_engine u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic int effective_count();
        return (vtx_reg > MAX_VERTICES) ? MAX_VERTICES : int'(vtx_reg);
    endfunction

    // Applies one request to the shadow graph and returns the result it must produce.
    function automatic graph_result_t predict_graph_step(input logic [FUNC_W-1:0] f,
                                                         input logic [VTX_W-1:0] a,
                                                         input logic [VTX_W-1:0] b);
        graph_result_t           r;
        int                      n;
        int                      ind;
        logic [MAX_VERTICES-1:0] live;
        logic [MAX_VERTICES-1:0] seen;
        logic [MAX_VERTICES-1:0] prev;
        r    = '0;
        n    = effective_count();
        live = (n >= MAX_VERTICES) ? '1 : ((64'd1 << n) - 64'd1);
        if (f != FUNC_UNUSED && (int'(a) >= n || int'(b) >= n)) begin
            r.bad = 1'b1;
            bad_hits++;
        end else if (f == FUNC_INSERT) begin
            if (a != b && !adj_rows[a][b]) begin
                adj_rows[a][b] = 1'b1;
                arc_total++;
                r.changed = 1'b1;
            end
        end else if (f == FUNC_REMOVE) begin
            if (adj_rows[a][b]) begin
                adj_rows[a][b] = 1'b0;
                if (arc_total > 0) arc_total--;
                r.changed = 1'b1;
            end
        end else if (f == FUNC_QUERY) begin
            r.out_deg = VTX_W'($countones(adj_rows[a] & live));
            ind = 0;
            for (int k = 0; k < n; k++) begin
                if (adj_rows[k][b]) ind++;
            end
            r.in_deg = VTX_W'(ind);
            // Grow the set of reached vertices until it stops changing.
            seen = 64'd1 << a;
            do begin
                prev = seen;
                for (int k = 0; k < MAX_VERTICES; k++) begin
                    if (prev[k]) seen |= adj_rows[k] & live;
                end
            end while (seen != prev);
            r.reach = seen[b];
            queries_sent++;
            if (r.reach) reach_hits++;
        end
        r.arcs = ARC_W'(arc_total);
        return r;
    endfunction

    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [VTX_W-1:0] a,
                                input logic [VTX_W-1:0] b);
        while (!steady_flow && $urandom_range(0, 99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, b, a};
        s_tuser  <= f;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_graph_step(f, a, b));
        requests_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_vertex_count(input logic [CNT_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        vtx_reg = value;
        settings_used++;
    endtask

    // Mostly in-range vertices, often a neighbor pair so that long paths form.
    task automatic send_random_request();
        logic [FUNC_W-1:0] f;
        logic [VTX_W-1:0]  a;
        logic [VTX_W-1:0]  b;
        int                n;
        int                pick;
        n    = effective_count();
        pick = $urandom_range(0, 99);
        if (pick < 42) f = FUNC_INSERT;
        else if (pick < 62) f = FUNC_REMOVE;
        else if (pick < 95) f = FUNC_QUERY;
        else f = FUNC_UNUSED;
        if (n == 0 || $urandom_range(0, 99) < 8) a = VTX_W'($urandom_range(0, 63));
        else a = VTX_W'($urandom_range(0, n - 1));
        if (n == 0 || $urandom_range(0, 99) < 8) b = VTX_W'($urandom_range(0, 63));
        else b = VTX_W'($urandom_range(0, n - 1));
        if (f != FUNC_QUERY && int'(a) + 1 < n && $urandom_range(0, 1) == 1) b = a + VTX_W'(1);
        send_request(f, a, b);
    endtask

    always @(posedge aclk) begin
        graph_result_t got;
        graph_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.reach   = m_tdata[0];
            got.out_deg = m_tdata[6:1];
            got.in_deg  = m_tdata[12:7];
            got.arcs    = m_tdata[24:13];
            got.changed = m_tdata[25];
            got.bad     = m_tdata[26];
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result 0x%08h with no request pending", m_tdata));
            end else begin
                want = expected_results.pop_front();
                if (got.reach !== want.reach)
                    report_mismatch($sformatf("reachable %0d, wanted %0d",
                                              got.reach, want.reach));
                if (got.out_deg !== want.out_deg)
                    report_mismatch($sformatf("out_degree %0d, wanted %0d",
                                              got.out_deg, want.out_deg));
                if (got.in_deg !== want.in_deg)
                    report_mismatch($sformatf("in_degree %0d, wanted %0d",
                                              got.in_deg, want.in_deg));
                if (got.arcs !== want.arcs)
                    report_mismatch($sformatf("arc_count %0d, wanted %0d",
                                              got.arcs, want.arcs));
                if (got.changed !== want.changed)
                    report_mismatch($sformatf("changed %0d, wanted %0d",
                                              got.changed, want.changed));
                if (got.bad !== want.bad)
                    report_mismatch($sformatf("bad_vertex %0d, wanted %0d",
                                              got.bad, want.bad));
            end
        end
        m_tready <= steady_flow || ($urandom_range(0, 99) >= 21);
    end

    // Self-loops, duplicates, absent removals, paths and the unused function code.
    task automatic test_directed_updates();
        send_request(FUNC_INSERT, 6'd0, 6'd63);
        send_request(FUNC_INSERT, 6'd63, 6'd0);
        send_request(FUNC_INSERT, 6'd0, 6'd63);
        send_request(FUNC_INSERT, 6'd5, 6'd5);
        send_request(FUNC_REMOVE, 6'd1, 6'd2);
        send_request(FUNC_QUERY, 6'd0, 6'd0);
        send_request(FUNC_QUERY, 6'd63, 6'd63);
        send_request(FUNC_INSERT, 6'd0, 6'd1);
        send_request(FUNC_INSERT, 6'd1, 6'd2);
        send_request(FUNC_QUERY, 6'd0, 6'd2);
        send_request(FUNC_QUERY, 6'd2, 6'd0);
        send_request(FUNC_REMOVE, 6'd63, 6'd0);
        send_request(FUNC_QUERY, 6'd63, 6'd0);
        send_request(FUNC_UNUSED, 6'd63, 6'd63);
    endtask

    // Out-of-range vertices, a zero count, a count above the maximum and a shrunk graph.
    task automatic test_vertex_limits();
        write_vertex_count(7'd1);
        send_request(FUNC_QUERY, 6'd0, 6'd0);
        send_request(FUNC_INSERT, 6'd0, 6'd1);
        send_request(FUNC_QUERY, 6'd1, 6'd0);
        write_vertex_count(7'd0);
        send_request(FUNC_QUERY, 6'd0, 6'd0);
        send_request(FUNC_UNUSED, 6'd0, 6'd0);
        write_vertex_count(7'd127);
        send_request(FUNC_QUERY, 6'd0, 6'd63);
        send_request(FUNC_QUERY, 6'd63, 6'd63);
        write_vertex_count(7'd2);
        send_request(FUNC_QUERY, 6'd0, 6'd1);
        send_request(FUNC_REMOVE, 6'd1, 6'd2);
    endtask

    // Full fan-out and fan-in on the widest graph, with both sides never idling.
    task automatic test_back_to_back();
        write_vertex_count(7'd64);
        steady_flow = 1'b1;
        for (int k = 1; k < MAX_VERTICES; k++) begin
            send_request(FUNC_INSERT, 6'd0, VTX_W'(k));
            send_request(FUNC_INSERT, VTX_W'(k), 6'd63);
        end
        send_request(FUNC_QUERY, 6'd0, 6'd63);
        for (int i = 0; i < 80; i++) send_random_request();
        steady_flow = 1'b0;
    endtask

    task automatic test_random_graphs();
        logic [CNT_W-1:0] counts [12] = '{7'd3, 7'd64, 7'd8, 7'd1, 7'd127, 7'd16,
                                          7'd0, 7'd5, 7'd40, 7'd2, 7'd12, 7'd6};
        foreach (counts[p]) begin
            write_vertex_count(counts[p]);
            for (int i = 0; i < 110; i++) send_random_request();
        end
    endtask

    initial begin
        foreach (adj_rows[k]) adj_rows[k] = '0;
        arc_total   = 0;
        vtx_reg     = 7'd64;
        steady_flow = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_updates();
        test_vertex_limits();
        test_back_to_back();
        test_random_graphs();

        wait_idle();
        repeat (200) @(posedge aclk);
        $display("Ran %0d requests over %0d vertex-count settings: %0d queries, %0d reachable,",
                 requests_sent, settings_used, queries_sent, reach_hits);
        $display("%0d with a vertex out of range, %0d mismatches.", bad_hits, errors);
        if (errors == 0) begin
            $display("** digraph_reachability_engine: PASSED **");
        end else begin
            $display("** digraph_reachability_engine: FAILED **");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results still pending.", expected_results.size());
        $display("** digraph_reachability_engine: FAILED **");
        $finish;
    end

endmodule

// ===== digraph_reachability_engine.f =====
+incdir+rtl
rtl/dre_pkg.sv
rtl/dre_front.sv
rtl/dre_queue.sv
rtl/dre_back.sv
rtl/digraph_reachability_engine.sv
tb/sv/tb_digraph_reachability_engine.sv
